// ===== src/sdx_pkg.sv =====
// ----------------------------------------------------------------------------
// sdx_pkg
// shared types, constants and the letter code table of the soundex encoder
// ----------------------------------------------------------------------------
package sdx_pkg;

    localparam int unsigned CODE_LENGTH_DEF = 4;
    localparam int unsigned OUT_DIGITS      = 3;

    typedef logic [2:0] code_t;
    typedef logic [6:0] ascii_t;

    localparam ascii_t EMPTY_CHAR = 7'd48;
    localparam code_t  CODE_NONE  = 3'd0;

    typedef struct packed {
        logic   is_letter;
        ascii_t upper;
        code_t  code;
    } letter_info_t;

    function automatic code_t letter_code(input logic [4:0] idx);
        code_t code;
        case (idx) inside
            5'd1, 5'd5, 5'd15, 5'd21:                       code = 3'd1;
            5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: code = 3'd2;
            5'd3, 5'd19:                                    code = 3'd3;
            5'd11:                                          code = 3'd4;
            5'd12, 5'd13:                                   code = 3'd5;
            5'd17:                                          code = 3'd6;
            default:                                        code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== src/sdx_if.sv =====
// ----------------------------------------------------------------------------
// sdx_if
// valid/ready channels of the soundex encoder: name bytes in, codes out
// ----------------------------------------------------------------------------
interface sdx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       has_char;
    logic       end_of_name;

    modport source (output valid, output char_in, output has_char, output end_of_name,
                    input ready);
    modport sink   (input valid, input char_in, input has_char, input end_of_name,
                    output ready);
endinterface

interface sdx_code_if;
    logic               valid;
    logic               ready;
    sdx_pkg::ascii_t    first_char;
    sdx_pkg::code_t     digit_one;
    sdx_pkg::code_t     digit_two;
    sdx_pkg::code_t     digit_three;

    modport source (output valid, output first_char, output digit_one, output digit_two,
                    output digit_three, input ready);
    modport sink   (input valid, input first_char, input digit_one, input digit_two,
                    input digit_three, output ready);
endinterface

// ===== src/sdx_letter_map.sv =====
// ----------------------------------------------------------------------------
// sdx_letter_map
// classifies one byte: ascii letter check, uppercase form and phonetic code
// ----------------------------------------------------------------------------
module sdx_letter_map (
    input  logic [7:0]            char_byte,
    output sdx_pkg::letter_info_t info
);
    import sdx_pkg::*;

    logic       is_lower;
    logic       is_upper;
    logic [7:0] up_byte;
    logic [7:0] idx_byte;

    always_comb
    begin
        is_lower = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
        is_upper = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
        up_byte  = is_lower ? (char_byte - 8'd32) : char_byte;
        idx_byte = up_byte - 8'h41;

        info.is_letter = is_lower || is_upper;
        info.upper     = up_byte[6:0];
        info.code      = letter_code(idx_byte[4:0]);
    end

endmodule

// ===== src/soundex_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// soundex_encoder_unit
// streaming soundex encoder: name bytes in, one four-character code per name
// ----------------------------------------------------------------------------
// chars carries one byte per transaction with has_char and end_of_name;
// bytes that are not ascii letters are dropped. a transaction with
// end_of_name set closes the name (its byte, if has_char, counts first) and
// one transaction on codes follows: the uppercased first letter ('0' for a
// name without letters) and three digits, zero padded.
// throughput: one byte transaction per cycle while chars is ready; the name
// registers take each accepted byte through the letter table.
// the code is valid in the cycle after the closing byte is taken.
// the code sits in a one-entry result register; chars stays ready while that
// register is empty or being drained in the same cycle, so a stalled codes
// sink holds off chars only when a finished code is still waiting.
// reset clears the name registers and the result valid flag; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module soundex_encoder_unit #(
    parameter int unsigned CODE_LENGTH = sdx_pkg::CODE_LENGTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sdx_char_if.sink       chars,
    sdx_code_if.source     codes
);
    import sdx_pkg::*;

    localparam int unsigned MAX_DIGITS  = CODE_LENGTH - 1;
    localparam int unsigned KEPT_DIGITS = (MAX_DIGITS < OUT_DIGITS) ? MAX_DIGITS : OUT_DIGITS;
    localparam int unsigned CNT_W       = $clog2(KEPT_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(KEPT_DIGITS);

    letter_info_t info;

    logic                          letter_seen_reg, letter_seen_next;
    ascii_t                        first_letter_reg, first_letter_next;
    code_t                         previous_code_reg, previous_code_next;
    logic [CNT_W-1:0]              digit_count_reg, digit_count_next;
    code_t [KEPT_DIGITS-1:0]       digit_store_reg, digit_store_next;

    logic                          out_valid_reg;
    ascii_t                        first_char_reg;
    code_t [OUT_DIGITS-1:0]        digits_reg;
    code_t [OUT_DIGITS-1:0]        digits_pad;
    ascii_t                        first_res;
    logic                          take;

    sdx_letter_map u_letter_map (
        .char_byte (chars.char_in),
        .info      (info)
    );

    assign chars.ready = !out_valid_reg || codes.ready;
    assign take        = chars.valid && chars.ready;

    // name update for the byte on the channel
    always_comb
    begin
        letter_seen_next   = letter_seen_reg;
        first_letter_next  = first_letter_reg;
        previous_code_next = previous_code_reg;
        digit_count_next   = digit_count_reg;
        digit_store_next   = digit_store_reg;
        if (chars.has_char && info.is_letter)
        begin
            if (!letter_seen_reg)
            begin
                letter_seen_next  = 1'b1;
                first_letter_next = info.upper;
            end
            else if (info.code != CODE_NONE && info.code != previous_code_reg &&
                     digit_count_reg != CNT_FULL)
            begin
                for (int k = 0; k < KEPT_DIGITS; k++)
                begin
                    if (digit_count_reg == CNT_W'(k))
                    begin
                        digit_store_next[k] = info.code;
                    end
                end
                digit_count_next = digit_count_reg + 1'b1;
            end
            previous_code_next = info.code;
        end
    end

    always_comb
    begin
        digits_pad = '0;
        for (int k = 0; k < KEPT_DIGITS; k++)
        begin
            digits_pad[k] = digit_store_next[k];
        end
        first_res = letter_seen_next ? first_letter_next : EMPTY_CHAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letter_seen_reg   <= 1'b0;
            first_letter_reg  <= '0;
            previous_code_reg <= CODE_NONE;
            digit_count_reg   <= '0;
            digit_store_reg   <= '0;
        end
        else if (take)
        begin
            if (chars.end_of_name)
            begin
                letter_seen_reg   <= 1'b0;
                first_letter_reg  <= '0;
                previous_code_reg <= CODE_NONE;
                digit_count_reg   <= '0;
                digit_store_reg   <= '0;
            end
            else
            begin
                letter_seen_reg   <= letter_seen_next;
                first_letter_reg  <= first_letter_next;
                previous_code_reg <= previous_code_next;
                digit_count_reg   <= digit_count_next;
                digit_store_reg   <= digit_store_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && chars.end_of_name)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (codes.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && chars.end_of_name)
        begin
            first_char_reg <= first_res;
            digits_reg     <= digits_pad;
        end
    end

    assign codes.valid       = out_valid_reg;
    assign codes.first_char  = first_char_reg;
    assign codes.digit_one   = digits_reg[0];
    assign codes.digit_two   = digits_reg[1];
    assign codes.digit_three = digits_reg[2];

`ifndef SYNTHESIS
    a_end_gives_code: assert property (@(posedge clk) disable iff (!rst_n)
        take && chars.end_of_name |=> codes.valid)
        else $error("closing transaction gave no code");

    a_end_clears_name: assert property (@(posedge clk) disable iff (!rst_n)
        take && chars.end_of_name |=> !letter_seen_reg && digit_count_reg == '0)
        else $error("name registers not cleared after closing transaction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CNT_FULL)
        else $error("digit count past its limit");

    a_empty_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        codes.valid && codes.first_char == EMPTY_CHAR |->
            codes.digit_one == CODE_NONE && codes.digit_two == CODE_NONE &&
            codes.digit_three == CODE_NONE)
        else $error("digits present in a code without letters");

    a_digit_order: assert property (@(posedge clk) disable iff (!rst_n)
        codes.valid && codes.digit_two != CODE_NONE |-> codes.digit_one != CODE_NONE)
        else $error("digit gap in code");
`endif

endmodule

// ===== bench/soundex_encoder_unit_checker.sv =====
// ----------------------------------------------------------------------------
// soundex_encoder_unit_checker
// watches the char and code channels, predicts each soundex code from the
// accepted bytes and compares every code transaction field by field
// ----------------------------------------------------------------------------
module soundex_encoder_unit_checker #(
    parameter int unsigned CODE_LENGTH = sdx_pkg::CODE_LENGTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    sdx_char_if   chars,
    sdx_code_if   codes,
    output int    fail_count,
    output int    pending,
    output int    names_done,
    output int    letterless_names
);
    timeunit 1ns;
    timeprecision 1ps;

    import sdx_pkg::*;

    localparam int unsigned DIGIT_SLOTS =
        (CODE_LENGTH - 1 < OUT_DIGITS) ? CODE_LENGTH - 1 : OUT_DIGITS;
    localparam int MAX_REPORTS = 30;

    typedef struct packed {
        ascii_t first_char;
        code_t  digit_one;
        code_t  digit_two;
        code_t  digit_three;
    } soundex_code_t;

    soundex_code_t code_q[$];

    logic        name_has_letter;
    ascii_t      head_letter;
    code_t       last_group;
    int unsigned kept;
    code_t       kept_digit[OUT_DIGITS];
    int          reports;

    function automatic code_t sound_group(input logic [7:0] up);
        code_t grp;
        case (up)
            "B", "F", "P", "V":                     grp = 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": grp = 3'd2;
            "D", "T":                               grp = 3'd3;
            "L":                                    grp = 3'd4;
            "M", "N":                               grp = 3'd5;
            "R":                                    grp = 3'd6;
            default:                                grp = CODE_NONE;
        endcase
        return grp;
    endfunction

    task automatic clear_name();
        name_has_letter = 1'b0;
        head_letter     = '0;
        last_group      = CODE_NONE;
        kept            = 0;
        foreach (kept_digit[i])
            kept_digit[i] = CODE_NONE;
    endtask

    task automatic take_char(input logic [7:0] c);
        logic [7:0] up;
        code_t      grp;
        if (c >= "a" && c <= "z")
            up = c - 8'd32;
        else if (c >= "A" && c <= "Z")
            up = c;
        else
            return;
        grp = sound_group(up);
        if (!name_has_letter)
        begin
            name_has_letter = 1'b1;
            head_letter     = up[6:0];
        end
        else if (grp != CODE_NONE && grp != last_group && kept < DIGIT_SLOTS)
        begin
            kept_digit[kept] = grp;
            kept++;
        end
        last_group = grp;
    endtask

    task automatic close_name();
        soundex_code_t want;
        want.first_char  = name_has_letter ? head_letter : EMPTY_CHAR;
        want.digit_one   = kept_digit[0];
        want.digit_two   = kept_digit[1];
        want.digit_three = kept_digit[2];
        if (!name_has_letter)
            letterless_names++;
        code_q.push_back(want);
        names_done++;
        clear_name();
    endtask

    task automatic field_check(input string field, input int want, input logic [6:0] got);
        if (got !== want[6:0])
        begin
            fail_count++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            reports++;
        end
    endtask

    task automatic compare_code();
        soundex_code_t want;
        if (code_q.size() == 0)
        begin
            fail_count++;
            if (reports < MAX_REPORTS)
                $display("%0t: unexpected code, expected none, actual %0d %0d %0d %0d",
                         $time, codes.first_char, codes.digit_one, codes.digit_two,
                         codes.digit_three);
            reports++;
            return;
        end
        want = code_q.pop_front();
        field_check("first_char", want.first_char, codes.first_char);
        field_check("digit_one", want.digit_one, {4'b0, codes.digit_one});
        field_check("digit_two", want.digit_two, {4'b0, codes.digit_two});
        field_check("digit_three", want.digit_three, {4'b0, codes.digit_three});
    endtask

    initial
    begin
        fail_count       = 0;
        pending          = 0;
        names_done       = 0;
        letterless_names = 0;
        reports          = 0;
        clear_name();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_name();
            code_q.delete();
        end
        else
        begin
            // code transaction first: it always belongs to an earlier name
            if (codes.valid === 1'b1 && codes.ready === 1'b1)
                compare_code();
            if (chars.valid === 1'b1 && chars.ready === 1'b1)
            begin
                if (chars.has_char)
                    take_char(chars.char_in);
                if (chars.end_of_name)
                    close_name();
            end
        end
        pending = code_q.size();
    end

endmodule

// ===== bench/soundex_encoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// soundex_encoder_unit_tb
// drives directed and random names into the soundex encoder with random
// gaps and sink stalls; the checker predicts and compares every code
// ----------------------------------------------------------------------------
module soundex_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdx_pkg::*;

    localparam int NAME_BYTES  = 1800;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int pending;
    int names_done;
    int letterless_names;
    int bytes_sent;
    int codes_taken;
    bit fast_in;
    bit fast_out;

    sdx_char_if chars();
    sdx_code_if codes();

    soundex_encoder_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .codes (codes)
    );

    soundex_encoder_unit_checker checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .chars            (chars),
        .codes            (codes),
        .fail_count       (fail_count),
        .pending          (pending),
        .names_done       (names_done),
        .letterless_names (letterless_names)
    );

    always #5 clk = ~clk;

    task automatic send_byte(input logic [7:0] c, input logic has, input logic eon);
        int gap;
        gap = fast_in ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            chars.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars.valid       <= 1'b1;
        chars.char_in     <= c;
        chars.has_char    <= has;
        chars.end_of_name <= eon;
        do
            @(posedge clk);
        while (chars.ready !== 1'b1);
        if (has || eon)
            bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit end_on_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b1, end_on_last && i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_byte(input logic [7:0] prev);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        else if (r == 1)
            return prev;
        else if (r < 9)
            return 8'(8'("A") + $urandom_range(0, 25));
        else
            return 8'(8'("a") + $urandom_range(0, 25));
    endfunction

    task automatic send_random_name();
        int         len;
        bit         split_end;
        logic [7:0] c;
        c   = "a";
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
        split_end = ($urandom_range(0, 3) == 0) || len == 0;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            c = pick_byte(c);
            send_byte(c, 1'b1, !split_end && k == len - 1);
        end
        if (split_end)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // stimulus
    initial
    begin
        rst_n             <= 1'b0;
        chars.valid       <= 1'b0;
        chars.char_in     <= '0;
        chars.has_char    <= 1'b0;
        chars.end_of_name <= 1'b0;
        bytes_sent = 0;
        fast_in    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // one-letter name closed in the same transaction
        send_byte("a", 1'b1, 1'b1);
        // empty end transaction alone
        send_byte(8'h00, 1'b0, 1'b1);
        // bytes that are not letters only
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte("@", 1'b1, 1'b0);
        send_byte("[", 1'b1, 1'b0);
        send_byte("{", 1'b1, 1'b1);
        // idle transaction, then a long name whose extra digits drop
        send_byte("Q", 1'b0, 1'b0);
        send_text("zBcdlm", 1'b1);
        // equal neighbors, vowel and h between equal codes
        send_text("Tdadhtr", 1'b1);

        while (bytes_sent < NAME_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                fast_in = !fast_in;
            send_random_name();
        end
        chars.valid <= 1'b0;
    end

    // code sink with random stalls and two long hold-offs
    initial
    begin
        int gap;
        codes.ready <= 1'b0;
        codes_taken = 0;
        fast_out    = 1'b0;
        @(posedge clk iff rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                fast_out = !fast_out;
            if (codes_taken == 30 || codes_taken == 120)
                gap = HOLD_CYCLES;
            else
                gap = fast_out ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                codes.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            codes.ready <= 1'b1;
            do
                @(posedge clk);
            while (codes.valid !== 1'b1);
            codes_taken++;
        end
    end

    // verdict
    initial
    begin
        int waited;
        wait (bytes_sent >= NAME_BYTES && chars.valid === 1'b0);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending != 0)
            $display("%0t: %0d code(s) never arrived", $time, pending);
        $display("checked %0d names (%0d without letters) from %0d byte transactions,",
                 names_done, letterless_names, bytes_sent);
        $display("with random gaps on both channels and two long code sink hold-offs");
        if (fail_count == 0 && pending == 0)
            $display("soundex_encoder_unit regression: pass");
        else
            $display("soundex_encoder_unit regression: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("soundex_encoder_unit regression: fail");
        $finish;
    end

endmodule
